// File: hdl/uart_command_frame_parser_core_defines.svh
// ----------------------------------------------------------------------------
// UART command frame parser - assertion macros
// Shared concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef UART_COMMAND_FRAME_PARSER_CORE_DEFINES_SVH
`define UART_COMMAND_FRAME_PARSER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled in reset
`define UCFP_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ucfp assertion failed");

// next-cycle implication, disabled in reset
`define UCFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ucfp assertion failed");

`else

`define UCFP_ASSERT_IMPL(label, clk, rst, ante, cons)
`define UCFP_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: hdl/ucfp_pkg.sv
// ----------------------------------------------------------------------------
// ucfp_pkg
// Types, constants and table functions of the UART command frame parser.
// ----------------------------------------------------------------------------
package ucfp_pkg;

  // field widths
  localparam int ByteW  = 8;
  localparam int ModeW  = 1;
  localparam int KindW  = 2;
  localparam int CmdW   = 4;
  localparam int ArgW   = 6;
  localparam int TickW  = 16;
  localparam int SyncW  = 32;
  localparam int CfgIdxW = 1;
  localparam int CfgDataW = 32;

  // sync word length in characters
  localparam int SyncLength = 4;
  localparam int MatchW = (SyncLength > 1) ? $clog2(SyncLength) : 1;
  localparam int SyncChars = SyncW / ByteW;

  // special bytes and limits
  localparam logic [ByteW-1:0] EscapeByte = 8'd69;
  localparam logic [ByteW-1:0] MaxCommand = 8'd10;
  localparam logic [ByteW-1:0] LowerA     = 8'd97;
  localparam logic [ByteW-1:0] LowerZ     = 8'd122;
  localparam logic [ByteW-1:0] CaseOffset = 8'd32;

  // reset values of the registers
  localparam logic [SyncW-1:0] SyncWordReset = 32'h4E4F_4445;
  localparam logic [TickW-1:0] TimeoutReset  = 16'd1000;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegSyncWord = 1'd0;
  localparam logic [CfgIdxW-1:0] RegTimeout  = 1'd1;

  // input mode codes
  localparam logic [ModeW-1:0] ModeByte = 1'b0;
  localparam logic [ModeW-1:0] ModeTick = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SYNC,
    PH_CMD,
    PH_ESC,
    PH_ARGS
  } phase_t;

  typedef enum logic [KindW-1:0] {
    KIND_ARG     = 2'd0,
    KIND_NOARGS  = 2'd1,
    KIND_TIMEOUT = 2'd2,
    KIND_UNKNOWN = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [CmdW-1:0]   command;
    logic [ArgW-1:0]   arg_index;
    logic [ByteW-1:0]  arg_byte;
    logic              last;
  } result_t;

  // argument byte count per command code
  function automatic logic [ArgW-1:0] arg_count(logic [CmdW-1:0] code);
    logic [ArgW-1:0] n;
    case (code)
      4'd0:    n = 6'd1;
      4'd1:    n = 6'd6;
      4'd2:    n = 6'd6;
      4'd3:    n = 6'd45;
      4'd7:    n = 6'd8;
      4'd8:    n = 6'd3;
      4'd9:    n = 6'd1;
      default: n = 6'd0;
    endcase
    return n;
  endfunction

  // sync character at position idx; first character in the top byte
  function automatic logic [ByteW-1:0] sync_char(logic [SyncW-1:0] word,
                                                 logic [MatchW-1:0] idx);
    int pos;
    logic [ByteW-1:0] ch;
    pos = SyncLength - 1 - int'(idx);
    ch = '0;
    for (int p = 0; p < SyncChars; p++) begin
      if (pos == p) begin
        ch = word[ByteW*p +: ByteW];
      end
    end
    return ch;
  endfunction

endpackage

// File: hdl/ucfp_rx_if.sv
// ----------------------------------------------------------------------------
// ucfp_rx_if
// Input channel: received byte or timer tick, valid/ready.
// ----------------------------------------------------------------------------
interface ucfp_rx_if;
  import ucfp_pkg::*;

  logic             valid;
  logic             ready;
  logic [ModeW-1:0] mode;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output mode, output rx_byte, input ready);
  modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

// File: hdl/ucfp_res_if.sv
// ----------------------------------------------------------------------------
// ucfp_res_if
// Result channel: one parsed frame event per beat, valid/ready.
// ----------------------------------------------------------------------------
interface ucfp_res_if;
  import ucfp_pkg::*;

  logic             valid;
  logic             ready;
  logic [KindW-1:0] kind;
  logic [CmdW-1:0]  command;
  logic [ArgW-1:0]  arg_index;
  logic [ByteW-1:0] arg_byte;
  logic             last;

  modport source (output valid, output kind, output command, output arg_index,
                  output arg_byte, output last, input ready);
  modport sink   (input valid, input kind, input command, input arg_index,
                  input arg_byte, input last, output ready);
endinterface

// File: hdl/ucfp_cfg_if.sv
// ----------------------------------------------------------------------------
// ucfp_cfg_if
// Configuration write channel: register index and data, valid/ready.
// ----------------------------------------------------------------------------
interface ucfp_cfg_if;
  import ucfp_pkg::*;

  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/ucfp_step.sv
// ----------------------------------------------------------------------------
// ucfp_step
// Frame state machine: one registered item in, state update and at most
// one result out per fire.
// ----------------------------------------------------------------------------
`include "uart_command_frame_parser_core_defines.svh"

module ucfp_step (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         fire,
  input  logic [ucfp_pkg::ModeW-1:0]   mode,
  input  logic [ucfp_pkg::ByteW-1:0]   rx_byte,
  input  logic [ucfp_pkg::SyncW-1:0]   sync_word,
  input  logic [ucfp_pkg::TickW-1:0]   timeout_ticks,
  output logic                         res_valid,
  output ucfp_pkg::result_t            res
);
  import ucfp_pkg::*;

  phase_t            phase, phase_next;
  logic [MatchW-1:0] match_count, match_count_next;
  logic [CmdW-1:0]   current_command, current_command_next;
  logic [ArgW-1:0]   args_remaining, args_remaining_next;
  logic [ArgW-1:0]   next_arg_index, next_arg_index_next;
  logic [TickW-1:0]  ticks_left, ticks_left_next;

  phase_t            phase_eff;
  logic [MatchW-1:0] match_eff;
  logic [ByteW-1:0]  upper;
  logic              sync_hit;
  logic              sync_done;
  logic [ArgW-1:0]   code_args;
  logic              code_unknown;
  logic              code_noargs;
  logic              args_last;
  logic              tick_expire;

  // shared decode
  always_comb begin
    phase_eff    = (phase == PH_IDLE) ? PH_SYNC : phase;
    match_eff    = (phase == PH_IDLE) ? '0 : match_count;
    upper        = (rx_byte >= LowerA && rx_byte <= LowerZ) ? rx_byte - CaseOffset
                                                            : rx_byte;
    sync_hit     = (upper == sync_char(sync_word, match_eff));
    sync_done    = sync_hit && (match_eff == MatchW'(SyncLength - 1));
    code_args    = arg_count(rx_byte[CmdW-1:0]);
    code_unknown = (rx_byte > MaxCommand);
    code_noargs  = !code_unknown && (code_args == '0);
    args_last    = (args_remaining <= ArgW'(1));
    tick_expire  = (phase != PH_IDLE) && (ticks_left <= TickW'(1));
  end

  // next phase
  always_comb begin
    phase_next = phase;
    if (fire) begin
      if (mode == ModeTick) begin
        if (tick_expire) begin
          phase_next = PH_IDLE;
        end
      end else begin
        case (phase_eff)
          PH_SYNC: begin
            phase_next = sync_done ? PH_CMD : PH_SYNC;
          end
          PH_CMD: begin
            if (rx_byte == EscapeByte) begin
              phase_next = PH_ESC;
            end else begin
              phase_next = (code_unknown || code_noargs) ? PH_IDLE : PH_ARGS;
            end
          end
          PH_ESC: begin
            phase_next = (code_unknown || code_noargs) ? PH_IDLE : PH_ARGS;
          end
          PH_ARGS: begin
            phase_next = args_last ? PH_IDLE : PH_ARGS;
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end
  end

  // counters and result
  always_comb begin
    match_count_next     = match_count;
    current_command_next = current_command;
    args_remaining_next  = args_remaining;
    next_arg_index_next  = next_arg_index;
    ticks_left_next      = ticks_left;
    res_valid            = 1'b0;
    res                  = '0;
    if (fire) begin
      if (mode == ModeTick) begin
        if (tick_expire) begin
          match_count_next     = '0;
          current_command_next = '0;
          args_remaining_next  = '0;
          next_arg_index_next  = '0;
          ticks_left_next      = '0;
          res_valid            = 1'b1;
          res.kind             = KIND_TIMEOUT;
          res.last             = 1'b1;
        end else if (phase != PH_IDLE) begin
          ticks_left_next = ticks_left - TickW'(1);
        end
      end else begin
        // first byte of a frame opens the timeout window
        if (phase == PH_IDLE) begin
          ticks_left_next = timeout_ticks;
        end
        match_count_next = match_eff;
        case (phase_eff)
          PH_SYNC: begin
            if (sync_hit && !sync_done) begin
              match_count_next = match_eff + MatchW'(1);
            end else begin
              match_count_next = '0;
            end
          end
          PH_CMD, PH_ESC: begin
            if (phase_eff == PH_CMD && rx_byte == EscapeByte) begin
              // wait for the escaped command byte
            end else if (code_unknown) begin
              current_command_next = '0;
              args_remaining_next  = '0;
              next_arg_index_next  = '0;
              ticks_left_next      = '0;
              res_valid            = 1'b1;
              res.kind             = KIND_UNKNOWN;
              res.last             = 1'b1;
            end else if (code_noargs) begin
              current_command_next = '0;
              args_remaining_next  = '0;
              next_arg_index_next  = '0;
              ticks_left_next      = '0;
              res_valid            = 1'b1;
              res.kind             = KIND_NOARGS;
              res.command          = rx_byte[CmdW-1:0];
              res.last             = 1'b1;
            end else begin
              current_command_next = rx_byte[CmdW-1:0];
              args_remaining_next  = code_args;
              next_arg_index_next  = '0;
            end
          end
          PH_ARGS: begin
            res_valid     = 1'b1;
            res.kind      = KIND_ARG;
            res.command   = current_command;
            res.arg_index = next_arg_index;
            res.arg_byte  = rx_byte;
            res.last      = args_last;
            if (args_last) begin
              match_count_next     = '0;
              current_command_next = '0;
              args_remaining_next  = '0;
              next_arg_index_next  = '0;
              ticks_left_next      = '0;
            end else begin
              args_remaining_next = args_remaining - ArgW'(1);
              next_arg_index_next = next_arg_index + ArgW'(1);
            end
          end
          default: begin
            match_count_next     = '0;
            current_command_next = '0;
            args_remaining_next  = '0;
            next_arg_index_next  = '0;
            ticks_left_next      = '0;
          end
        endcase
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      match_count     <= '0;
      current_command <= '0;
      args_remaining  <= '0;
      next_arg_index  <= '0;
      ticks_left      <= '0;
    end else begin
      phase           <= phase_next;
      match_count     <= match_count_next;
      current_command <= current_command_next;
      args_remaining  <= args_remaining_next;
      next_arg_index  <= next_arg_index_next;
      ticks_left      <= ticks_left_next;
    end
  end

  // checks
  `UCFP_ASSERT_IMPL(a_args_pending, clk, rst, phase == PH_ARGS, args_remaining != '0)
  `UCFP_ASSERT_IMPL(a_idle_clear, clk, rst, phase == PH_IDLE, ticks_left == '0 && match_count == '0)
  `UCFP_ASSERT_NEXT(a_last_idle, clk, rst, res_valid && res.last, phase == PH_IDLE)

endmodule

// File: hdl/ucfp_out_queue.sv
// ----------------------------------------------------------------------------
// ucfp_out_queue
// Two-entry result queue between the frame logic and the result channel.
// ----------------------------------------------------------------------------
`include "uart_command_frame_parser_core_defines.svh"

module ucfp_out_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  ucfp_pkg::result_t  push_data,
  input  logic               pop,
  output logic               full,
  output logic               head_valid,
  output ucfp_pkg::result_t  head
);
  import ucfp_pkg::*;

  result_t    entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [1:0] count_next;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = entry[rd_ptr];

  // occupancy
  always_comb begin
    count_next = count;
    case ({push, pop})
      2'b10:   count_next = count + 2'd1;
      2'b01:   count_next = count - 2'd1;
      default: count_next = count;
    endcase
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count_next;
    end
  end

  // payload storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  // checks
  `UCFP_ASSERT_IMPL(a_no_overflow, clk, rst, push, !full)
  `UCFP_ASSERT_IMPL(a_no_underflow, clk, rst, pop, head_valid)

endmodule

// File: hdl/uart_command_frame_parser_core.sv
// ----------------------------------------------------------------------------
// uart_command_frame_parser_core
// Parses sync word, command byte and argument bytes out of a UART byte
// stream with a per-frame timeout counted in timer ticks.
// ----------------------------------------------------------------------------
//  channel  dir  beat contents
//  rx_item  in   mode (byte/tick), rx_byte
//  result   out  kind, command, arg_index, arg_byte, last
//  cfg      in   index (0 sync_word, 1 timeout_ticks), data
//
//  One item per cycle while the result queue is not full; an item's result
//  is staged through the input register, then the result queue.
//  The input register advances whenever the two-entry result queue has a
//  free slot, so items keep flowing while one result waits downstream.
//  Reset returns the parser to idle and the registers to their defaults.
//  Config writes are always accepted and written at the edge that takes them.
// ----------------------------------------------------------------------------
module uart_command_frame_parser_core (
  input  logic        clk,
  input  logic        rst,
  ucfp_rx_if.sink     rx_item,
  ucfp_res_if.source  result,
  ucfp_cfg_if.sink    cfg
);
  import ucfp_pkg::*;

  logic             rx_q_valid;
  logic [ModeW-1:0] rx_q_mode;
  logic [ByteW-1:0] rx_q_byte;
  logic             step_fire;
  logic             q_full;
  logic             res_valid;
  result_t          res;
  logic             head_valid;
  result_t          head;
  logic             pop;

  logic [SyncW-1:0] sync_word;
  logic [TickW-1:0] timeout_ticks;

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_word     <= SyncWordReset;
      timeout_ticks <= TimeoutReset;
    end else if (cfg.valid) begin
      case (cfg.index)
        RegSyncWord: sync_word     <= cfg.data[SyncW-1:0];
        RegTimeout:  timeout_ticks <= cfg.data[TickW-1:0];
        default:     sync_word     <= sync_word;
      endcase
    end
  end

  // input register
  assign step_fire     = rx_q_valid && !q_full;
  assign rx_item.ready = !rx_q_valid || step_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_q_valid <= 1'b0;
    end else if (rx_item.ready) begin
      rx_q_valid <= rx_item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_item.valid && rx_item.ready) begin
      rx_q_mode <= rx_item.mode;
      rx_q_byte <= rx_item.rx_byte;
    end
  end

  // frame logic
  ucfp_step u_step (
    .clk           (clk),
    .rst           (rst),
    .fire          (step_fire),
    .mode          (rx_q_mode),
    .rx_byte       (rx_q_byte),
    .sync_word     (sync_word),
    .timeout_ticks (timeout_ticks),
    .res_valid     (res_valid),
    .res           (res)
  );

  // result queue
  assign pop = head_valid && result.ready;

  ucfp_out_queue u_out_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (step_fire && res_valid),
    .push_data  (res),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  assign result.valid     = head_valid;
  assign result.kind      = head.kind;
  assign result.command   = head.command;
  assign result.arg_index = head.arg_index;
  assign result.arg_byte  = head.arg_byte;
  assign result.last      = head.last;

endmodule

// File: verif/ucfp_frame_checker.sv
// ----------------------------------------------------------------------------
// ucfp_frame_checker
// Watches the byte/tick, result and register channels of the frame parser.
// Keeps its own model of the frame state, queues the event each accepted
// beat should cause and compares every result beat field by field.
// ----------------------------------------------------------------------------
module ucfp_frame_checker (
  input  logic clk,
  input  logic rst,
  ucfp_rx_if   rx_item,
  ucfp_res_if  result,
  ucfp_cfg_if  cfg,
  output int   mismatches,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import ucfp_pkg::*;

  // argument bytes taken by commands 0 to 10
  localparam logic [ArgW-1:0] ArgBytes [0:10] = '{
    6'd1, 6'd6, 6'd6, 6'd45, 6'd0, 6'd0, 6'd0, 6'd8, 6'd3, 6'd1, 6'd0
  };

  // register copies
  logic [SyncW-1:0] sync_reg;
  logic [TickW-1:0] timeout_reg;

  // frame state
  phase_t           fr_phase;
  logic [2:0]       sync_pos;
  logic [CmdW-1:0]  cur_cmd;
  logic [ArgW-1:0]  args_left;
  logic [ArgW-1:0]  arg_pos;
  logic [TickW-1:0] ticks_left;

  result_t frame_events_due [$];

  // one line per mismatch
  task automatic flag_error(string what, int got, int want);
    mismatches++;
    $display("%0t ucfp check: %s got %0d expected %0d", $realtime, what, got, want);
  endtask

  task automatic check_field(string what, logic [7:0] got, logic [7:0] want);
    if (got !== want) begin
      flag_error(what, int'(got), int'(want));
    end
  endtask

  function automatic logic [ByteW-1:0] sync_at(int idx);
    int pos;
    pos = SyncLength - 1 - idx;
    if (idx >= SyncLength || pos < 0 || pos >= SyncW / ByteW) begin
      return '0;
    end
    return sync_reg[ByteW*pos +: ByteW];
  endfunction

  task automatic close_frame();
    fr_phase   = PH_IDLE;
    sync_pos   = '0;
    cur_cmd    = '0;
    args_left  = '0;
    arg_pos    = '0;
    ticks_left = '0;
  endtask

  // command byte: unknown, complete without arguments, or start of arguments
  task automatic start_command(input logic [ByteW-1:0] code, output bit produced,
                               output result_t ev);
    produced = 1'b0;
    ev = '0;
    if (code > MaxCommand) begin
      close_frame();
      produced = 1'b1;
      ev.kind = KIND_UNKNOWN;
      ev.last = 1'b1;
    end else if (ArgBytes[code[CmdW-1:0]] == '0) begin
      close_frame();
      produced = 1'b1;
      ev.kind = KIND_NOARGS;
      ev.command = code[CmdW-1:0];
      ev.last = 1'b1;
    end else begin
      fr_phase  = PH_ARGS;
      cur_cmd   = code[CmdW-1:0];
      args_left = ArgBytes[code[CmdW-1:0]];
      arg_pos   = '0;
    end
  endtask

  // advance the frame state by one beat
  task automatic advance_parser(input logic m, input logic [ByteW-1:0] b,
                                output bit produced, output result_t ev);
    logic [ByteW-1:0] up;
    produced = 1'b0;
    ev = '0;
    if (m == ModeTick) begin
      // ticks only count inside a frame
      if (fr_phase != PH_IDLE) begin
        if (ticks_left <= 1) begin
          close_frame();
          produced = 1'b1;
          ev.kind = KIND_TIMEOUT;
          ev.last = 1'b1;
        end else begin
          ticks_left--;
        end
      end
    end else begin
      // first byte opens the frame and its timeout window
      if (fr_phase == PH_IDLE) begin
        fr_phase   = PH_SYNC;
        sync_pos   = '0;
        ticks_left = timeout_reg;
      end
      case (fr_phase)
        PH_SYNC: begin
          up = (b >= LowerA && b <= LowerZ) ? b - CaseOffset : b;
          if (up == sync_at(int'(sync_pos))) begin
            if (int'(sync_pos) + 1 >= SyncLength) begin
              sync_pos = '0;
              fr_phase = PH_CMD;
            end else begin
              sync_pos++;
            end
          end else begin
            sync_pos = '0;
          end
        end
        PH_CMD: begin
          if (b == EscapeByte) begin
            fr_phase = PH_ESC;
          end else begin
            start_command(b, produced, ev);
          end
        end
        PH_ESC: begin
          start_command(b, produced, ev);
        end
        PH_ARGS: begin
          produced = 1'b1;
          ev.kind = KIND_ARG;
          ev.command = cur_cmd;
          ev.arg_index = arg_pos;
          ev.arg_byte = b;
          ev.last = (args_left <= 1);
          if (ev.last) begin
            close_frame();
          end else begin
            args_left--;
            arg_pos++;
          end
        end
        default: begin
          close_frame();
        end
      endcase
    end
  endtask

  // per-edge monitor: registers, result compare, then prediction
  always @(posedge clk) begin
    bit produced;
    result_t ev;
    result_t want;
    if (rst) begin
      sync_reg    = SyncWordReset;
      timeout_reg = TimeoutReset;
      close_frame();
      frame_events_due.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          RegSyncWord: sync_reg = cfg.data[SyncW-1:0];
          RegTimeout:  timeout_reg = cfg.data[TickW-1:0];
          default: ;
        endcase
      end
      if (result.valid && result.ready) begin
        if (frame_events_due.size() == 0) begin
          flag_error("result beat with nothing due, kind", int'(result.kind), -1);
        end else begin
          want = frame_events_due.pop_front();
          check_field("kind", 8'(result.kind), 8'(want.kind));
          check_field("command", 8'(result.command), 8'(want.command));
          check_field("arg_index", 8'(result.arg_index), 8'(want.arg_index));
          check_field("arg_byte", result.arg_byte, want.arg_byte);
          check_field("last", 8'(result.last), 8'(want.last));
        end
      end
      if (rx_item.valid && rx_item.ready) begin
        advance_parser(rx_item.mode, rx_item.rx_byte, produced, ev);
        if (produced) begin
          frame_events_due.push_back(ev);
        end
      end
    end
    outstanding <= frame_events_due.size();
  end

endmodule

// File: verif/tb_uart_command_frame_parser_core.sv
// ----------------------------------------------------------------------------
// tb_uart_command_frame_parser_core
// Drives byte/tick beats and register writes into the frame parser with
// random gaps and result back-pressure; the frame checker does the scoring.
// ----------------------------------------------------------------------------
module tb_uart_command_frame_parser_core;
  timeunit 1ns;
  timeprecision 1ps;
  import ucfp_pkg::*;

  localparam logic [ByteW-1:0] UpperA = 8'h41;
  localparam logic [ByteW-1:0] UpperZ = 8'h5A;

  logic clk;
  logic rst;
  int   mismatch_count;
  int   pending_results;

  // stimulus shaping
  bit         no_gaps;
  int         tick_pct;
  int         items_sent;
  logic [SyncW-1:0] sync_now;
  logic [TickW-1:0] timeout_now;

  ucfp_rx_if  rx_item ();
  ucfp_res_if result ();
  ucfp_cfg_if cfg ();

  uart_command_frame_parser_core u_dut (
    .clk     (clk),
    .rst     (rst),
    .rx_item (rx_item),
    .result  (result),
    .cfg     (cfg)
  );

  ucfp_frame_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .rx_item     (rx_item),
    .result      (result),
    .cfg         (cfg),
    .mismatches  (mismatch_count),
    .outstanding (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // one beat on the input channel; valid stays up when the next has no gap
  task automatic send_item(logic m, logic [ByteW-1:0] b);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      rx_item.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_item.valid   <= 1'b1;
    rx_item.mode    <= m;
    rx_item.rx_byte <= b;
    do @(posedge clk); while (rx_item.ready !== 1'b1);
    items_sent++;
  endtask

  // byte beat, sometimes preceded by a stray tick
  task automatic send_byte(logic [ByteW-1:0] b);
    if ($urandom_range(0, 99) < tick_pct) begin
      send_item(ModeTick, 8'($urandom));
    end
    send_item(ModeByte, b);
  endtask

  // stop offering and wait until every due result is out
  task automatic settle();
    int waited;
    rx_item.valid <= 1'b0;
    repeat (2) @(posedge clk);
    waited = 0;
    while (pending_results != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (6) @(posedge clk);
  endtask

  // write both registers back to back
  task automatic apply_setting(logic [SyncW-1:0] s, logic [TickW-1:0] t);
    cfg.valid <= 1'b1;
    cfg.index <= RegSyncWord;
    cfg.data  <= s;
    do @(posedge clk); while (cfg.ready !== 1'b1);
    cfg.index <= RegTimeout;
    cfg.data  <= {16'h0, t};
    do @(posedge clk); while (cfg.ready !== 1'b1);
    cfg.valid   <= 1'b0;
    sync_now    = s;
    timeout_now = t;
  endtask

  function automatic logic [SyncW-1:0] letters_word();
    logic [SyncW-1:0] w;
    for (int i = 0; i < SyncW / ByteW; i++) begin
      w[ByteW*i +: ByteW] = 8'($urandom_range(int'(UpperA), int'(UpperZ)));
    end
    return w;
  endfunction

  // one frame: optional noise, sync word in mixed case, command, arguments
  task automatic send_frame();
    int sel;
    int code;
    int n;
    bit cut;
    logic [ByteW-1:0] ch;
    sel = $urandom_range(0, 99);
    cut = 1'b0;
    if (sel < 12) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
    end
    for (int i = 0; i < SyncLength; i++) begin
      ch = sync_now[ByteW*(SyncLength-1-i) +: ByteW];
      if (ch >= UpperA && ch <= UpperZ && $urandom_range(0, 1) == 1) begin
        ch = ch + CaseOffset;
      end
      send_byte(ch);
    end
    if (sel >= 12 && sel < 22) begin
      // unknown code, sometimes behind the escape byte
      if ($urandom_range(0, 1) == 1) begin
        send_byte(EscapeByte);
        send_byte(8'($urandom_range(11, 255)));
      end else begin
        code = $urandom_range(11, 254);
        send_byte(code == int'(EscapeByte) ? 8'hFF : 8'(code));
      end
    end else begin
      code = $urandom_range(0, 10);
      if ($urandom_range(0, 4) == 0) begin
        send_byte(EscapeByte);
      end
      send_byte(8'(code));
      n = int'(arg_count(4'(code)));
      // truncated frame, left to time out
      if (sel >= 90 && timeout_now <= 100) begin
        cut = 1'b1;
        n = (n > 0) ? $urandom_range(0, n - 1) : 0;
      end
      repeat (n) begin
        if ($urandom_range(0, 7) == 0) begin
          send_byte($urandom_range(0, 1) == 1 ? 8'hFF : 8'h00);
        end else begin
          send_byte(8'($urandom));
        end
      end
      if (cut) begin
        repeat ((timeout_now > 0) ? int'(timeout_now) : 1) send_item(ModeTick, 8'($urandom));
      end
    end
  endtask

  // result side: random stalls plus long hold-offs to back up the input
  initial begin
    int stall;
    int beats;
    result.ready <= 1'b0;
    beats = 0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 5);
      if (beats == 20 || beats == 250) begin
        stall = 80;
      end
      if (stall > 0) begin
        result.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result.ready <= 1'b1;
      do @(posedge clk); while (result.valid !== 1'b1);
      beats++;
    end
  end

  // main stimulus
  initial begin
    logic [ByteW-1:0] opening [];
    logic [SyncW-1:0] s;
    logic [TickW-1:0] t;
    int budget;
    int stop_at;

    rst             <= 1'b1;
    rx_item.valid   <= 1'b0;
    rx_item.mode    <= ModeByte;
    rx_item.rx_byte <= '0;
    cfg.valid       <= 1'b0;
    cfg.index       <= RegSyncWord;
    cfg.data        <= '0;
    no_gaps     = 1'b0;
    tick_pct    = 0;
    items_sent  = 0;
    sync_now    = SyncWordReset;
    timeout_now = TimeoutReset;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: idle tick, escaped escape, broken sync, zero and 0xFF bytes
    send_item(ModeTick, 8'hFF);
    opening = '{
      8'h6E, 8'h4F, 8'h64, 8'h45, EscapeByte, EscapeByte,  // "nOdE", esc, esc
      8'h4E, 8'h4E, 8'h4F, 8'h44, 8'h45,                   // "NNODE" stays hunting
      8'h4E, 8'h4F, 8'h44, 8'h45, 8'd9, 8'h00,             // one-arg command
      8'h4E, 8'h4F, 8'h44, 8'h45, 8'hFF                    // unknown code
    };
    foreach (opening[i]) begin
      send_item(ModeByte, opening[i]);
    end

    // random phases, each with its own register setting
    for (int p = 0; p < 6; p++) begin
      settle();
      case (p)
        0: begin s = SyncWordReset; t = TimeoutReset; tick_pct = 5; budget = 200; end
        1: begin s = letters_word(); t = 16'hFFFF; tick_pct = 5; budget = 150; end
        2: begin s = 32'hFFFF_FFFF; t = 16'd1; tick_pct = 15; budget = 120; end
        3: begin s = 32'h0000_0000; t = 16'd0; tick_pct = 10; budget = 80; end
        4: begin
          s = $urandom;
          t = 16'($urandom_range(2, 60));
          tick_pct = 8;
          budget = 150;
        end
        default: begin
          s = letters_word();
          t = 16'($urandom_range(10, 100));
          tick_pct = 5;
          budget = 150;
        end
      endcase
      apply_setting(s, t);
      stop_at = items_sent + budget;
      while (items_sent < stop_at) begin
        no_gaps = ($urandom_range(0, 3) == 0);
        send_frame();
      end
    end

    no_gaps = 1'b0;
    settle();
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("tb_uart_command_frame_parser_core: done, clean");
    end else begin
      $display("tb_uart_command_frame_parser_core: done, errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("tb_uart_command_frame_parser_core: done, errors");
    $finish;
  end

endmodule
